// File: hdl/sis_pkg.sv
// shared types and command codes for the sorted integer set table
package sis_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam int OUT_CNT_W = 7;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic                 found;
        logic [OUT_CNT_W-1:0] position;
        logic [OUT_CNT_W-1:0] count;
        logic                 status;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLEAR,
        OP_SEARCH_RD,
        OP_SEARCH_UPD,
        OP_CHECK_RD,
        OP_CHECK_UPD,
        OP_FULL,
        OP_INS_INIT,
        OP_UP_RD,
        OP_UP_WR,
        OP_INS_WR,
        OP_REM_INIT,
        OP_DN_RD,
        OP_DN_WR,
        OP_REM_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       search_done;
        logic       lo_in_range;
        logic       found;
        logic       full;
        logic       up_done;
        logic       dn_done;
    } dp_stat_t;

endpackage

// File: hdl/sis_dpath.sv
// datapath: element memory, search bounds, shift index, count and result register
module sis_dpath
    import sis_pkg::*;
#(
    parameter int SET_CAPACITY = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output out_item_t out_data
);

    localparam int AW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(SET_CAPACITY);

    logic signed [31:0] mem [SET_CAPACITY];
    logic signed [31:0] rd_data_reg;

    logic signed [31:0] value_reg;
    logic [1:0]         cmd_reg;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               found_reg, found_next;
    logic               full_reg, full_next;
    out_item_t          out_reg;

    logic [CW:0]        bound_sum;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      mid_plus;
    logic [CW-1:0]      idx_dec;
    logic [CW-1:0]      idx_inc;
    logic [CW+6:0]      lo_ext;
    logic [CW+6:0]      count_ext;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;

    assign bound_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = bound_sum[CW:1];
    assign mid_plus  = mid + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign idx_inc   = idx_reg + CW'(1);
    assign lo_ext    = {7'b0, lo_reg};
    assign count_ext = {7'b0, count_reg};

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = mid[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data_reg;
        case (cmd.op)
            OP_SEARCH_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = mid[AW-1:0];
            end
            OP_CHECK_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = lo_reg[AW-1:0];
            end
            OP_UP_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[AW-1:0];
            end
            OP_DN_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc[AW-1:0];
            end
            OP_UP_WR, OP_DN_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_reg[AW-1:0];
            end
            OP_INS_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = lo_reg[AW-1:0];
                wr_data = value_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        found_next = found_reg;
        full_next  = full_reg;
        case (cmd.op)
            OP_LOAD:
            begin
                lo_next    = '0;
                hi_next    = count_reg;
                found_next = 1'b0;
                full_next  = 1'b0;
            end
            OP_CLEAR:
            begin
                lo_next    = '0;
                count_next = '0;
            end
            OP_SEARCH_UPD:
            begin
                // narrow the bounds toward the first entry not below the value
                if (rd_data_reg < value_reg)
                begin
                    lo_next = mid_plus;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            OP_CHECK_UPD: found_next = (rd_data_reg == value_reg);
            OP_FULL:      full_next  = 1'b1;
            OP_INS_INIT:  idx_next   = count_reg;
            OP_UP_WR:     idx_next   = idx_dec;
            OP_INS_WR:    count_next = count_reg + CW'(1);
            OP_REM_INIT:  idx_next   = lo_reg;
            OP_DN_WR:     idx_next   = idx_inc;
            OP_REM_DONE:  count_next = count_reg - CW'(1);
            default:      idx_next   = idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        full_reg  <= full_next;
        if (cmd.op == OP_LOAD)
        begin
            value_reg <= in_data.value;
            cmd_reg   <= in_data.cmd;
        end
        if (cmd.out_load)
        begin
            out_reg.found    <= found_reg;
            out_reg.position <= lo_ext[OUT_CNT_W-1:0];
            out_reg.count    <= count_ext[OUT_CNT_W-1:0];
            out_reg.status   <= full_reg;
        end
    end

    assign stat.cmd         = cmd_reg;
    assign stat.search_done = (lo_reg >= hi_reg);
    assign stat.lo_in_range = (lo_reg < count_reg);
    assign stat.found       = found_reg;
    assign stat.full        = (count_reg == CAP);
    assign stat.up_done     = (idx_reg == lo_reg);
    assign stat.dn_done     = ({1'b0, idx_inc} >= {1'b0, count_reg});
    assign out_data         = out_reg;

endmodule

// File: hdl/sis_ctrl.sv
// controller: sequences search, membership check, shifts and result handoff
module sis_ctrl
    import sis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_SEARCH_CMP,
        S_CHECK,
        S_CHECK_CMP,
        S_DECIDE,
        S_UP,
        S_UP_WR,
        S_DN,
        S_DN_WR,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd.op         = OP_NONE;
        cmd.out_load   = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.cmd == CMD_CLEAR)
                begin
                    cmd.op     = OP_CLEAR;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cmd.op     = OP_SEARCH_RD;
                    state_next = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP:
            begin
                cmd.op     = OP_SEARCH_UPD;
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                if (stat.lo_in_range)
                begin
                    cmd.op     = OP_CHECK_RD;
                    state_next = S_CHECK_CMP;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_CHECK_CMP:
            begin
                cmd.op     = OP_CHECK_UPD;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                if (stat.cmd == CMD_INSERT && !stat.found)
                begin
                    if (stat.full)
                    begin
                        cmd.op = OP_FULL;
                    end
                    else
                    begin
                        cmd.op     = OP_INS_INIT;
                        state_next = S_UP;
                    end
                end
                else if (stat.cmd == CMD_REMOVE && stat.found)
                begin
                    cmd.op     = OP_REM_INIT;
                    state_next = S_DN;
                end
            end
            S_UP:
            begin
                // move entries up one slot from the top until the gap reaches the position
                if (stat.up_done)
                begin
                    cmd.op     = OP_INS_WR;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_UP_RD;
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                cmd.op     = OP_UP_WR;
                state_next = S_UP;
            end
            S_DN:
            begin
                if (stat.dn_done)
                begin
                    cmd.op     = OP_REM_DONE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_DN_RD;
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                cmd.op     = OP_DN_WR;
                state_next = S_DN;
            end
            S_DONE:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/sorted_integer_set_table.sv
// sorted integer set table: binary search, then entries shifted one slot at a time in memory
// (single read port); insert shifts up every entry at or above the position, remove shifts
// down every entry after it
// one item at a time: the next is accepted the cycle after its result is loaded; a
// result still waiting when the next one is ready holds the block
// reset clears the count and the handshake state; memory contents are left as they are
module sorted_integer_set_table
    import sis_pkg::*;
#(
    parameter int SET_CAPACITY = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sis_dpath #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule
